>>> sv/rotate_xor_block_cipher_16bit_macros.svh
// Assertion macros used by the top level of the rotate-and-xor cipher block.
`ifndef ROTATE_XOR_BLOCK_CIPHER_16BIT_MACROS_SVH
`define ROTATE_XOR_BLOCK_CIPHER_16BIT_MACROS_SVH

// Same-cycle implication, sampled on clk and switched off during rst.
`define RXBC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk and switched off during rst.
`define RXBC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> sv/rxbc_pkg.sv
// Package: types, constants and helpers for the rotate-and-xor cipher block.
`default_nettype none

package rxbc_pkg;

  localparam int BLOCK_W    = 16;
  localparam int NONCE_W    = 8;
  localparam int IDX_W      = 3;
  localparam int ROUNDS_W   = 4;
  localparam int MAX_ROUNDS = 2 ** ROUNDS_W - 1;

  localparam logic [ROUNDS_W-1:0] KEY_ROUND_MUL = 4'd9;
  localparam logic [7:0]          KEY_ROUND_XOR = 8'b10110100;
  localparam logic [BLOCK_W-1:0]  FINAL_WHITEN  = 16'b1010101010101010;

  typedef logic [BLOCK_W-1:0] block_t;

  typedef enum logic [1:0] {
    MODE_ECB = 2'd0,
    MODE_CBC = 2'd1,
    MODE_CTR = 2'd2
  } chain_mode_t;

  typedef enum logic [IDX_W-1:0] {
    REG_CIPHER_KEY    = 3'd0,
    REG_DIRECTION     = 3'd1,
    REG_CHAIN_MODE    = 3'd2,
    REG_INIT_VECTOR   = 3'd3,
    REG_COUNTER_NONCE = 3'd4
  } reg_index_t;

  typedef struct packed {
    block_t               key;
    logic                 decrypt;
    chain_mode_t          mode;
    block_t               iv;
    logic [NONCE_W-1:0]   nonce;
    logic [ROUNDS_W-1:0]  rounds;
  } cfg_t;

  // Only the low four bits of key*9 survive the final mod 16.
  function automatic logic [ROUNDS_W-1:0] round_count(input block_t key);
    return (key[ROUNDS_W-1:0] * KEY_ROUND_MUL) ^ KEY_ROUND_XOR[ROUNDS_W-1:0];
  endfunction

endpackage

`default_nettype wire

>>> sv/rxbc_in_if.sv
// Interface: input item channel of the cipher block.
`default_nettype none

interface rxbc_in_if;
  import rxbc_pkg::*;

  logic   valid;
  logic   ready;
  block_t block_in;
  logic   first_block;
  logic   tail_only;

  modport source (output valid, output block_in, output first_block, output tail_only,
                  input ready);
  modport sink   (input valid, input block_in, input first_block, input tail_only,
                  output ready);
endinterface

`default_nettype wire

>>> sv/rxbc_out_if.sv
// Interface: result item channel of the cipher block.
`default_nettype none

interface rxbc_out_if;
  import rxbc_pkg::*;

  logic   valid;
  logic   ready;
  block_t block_out;
  logic   tail_flag;

  modport source (output valid, output block_out, output tail_flag, input ready);
  modport sink   (input valid, input block_out, input tail_flag, output ready);
endinterface

`default_nettype wire

>>> sv/rxbc_cipher.sv
// Unrolled rotate-and-xor rounds for encryption and decryption, one block per pass.
`default_nettype none

module rxbc_cipher (
  input  rxbc_pkg::block_t                  data,
  input  rxbc_pkg::block_t                  key,
  input  logic [rxbc_pkg::ROUNDS_W-1:0]     rounds,
  input  logic                              decrypt,
  output rxbc_pkg::block_t                  result
);
  import rxbc_pkg::*;

  localparam int ROT_FIRST  = 9;
  localparam int ROT_SECOND = 12;

  function automatic block_t rol16(input block_t x, input logic [ROUNDS_W-1:0] amt);
    logic [2*BLOCK_W-1:0] d;
    d = {x, x} << amt;
    return d[2*BLOCK_W-1:BLOCK_W];
  endfunction

  function automatic block_t ror16(input block_t x, input logic [ROUNDS_W-1:0] amt);
    logic [2*BLOCK_W-1:0] d;
    d = {x, x} >> amt;
    return d[BLOCK_W-1:0];
  endfunction

  // Encryption walks the round index downwards, decryption upwards; a round
  // whose index is not below the round count passes its input through.
  block_t enc [MAX_ROUNDS+1];
  block_t dec [MAX_ROUNDS+1];

  assign enc[MAX_ROUNDS] = data;
  assign dec[0]          = data ^ FINAL_WHITEN;

  for (genvar i = 0; i < MAX_ROUNDS; i++) begin : g_round
    localparam logic [ROUNDS_W-1:0] Idx  = ROUNDS_W'(i);
    localparam logic [ROUNDS_W-1:0] AmtA = ROUNDS_W'(i + ROT_FIRST);
    localparam logic [ROUNDS_W-1:0] AmtB = ROUNDS_W'(ROT_SECOND - i);

    block_t e_step;
    block_t d_step;

    always_comb begin
      e_step = rol16(enc[i+1], AmtA) ^ key;
      e_step = rol16(e_step, AmtB) ^ ror16(key, Idx);
      d_step = ror16(dec[i] ^ ror16(key, Idx), AmtB) ^ key;
      d_step = ror16(d_step, AmtA);
    end

    assign enc[i]   = (Idx < rounds) ? e_step : enc[i+1];
    assign dec[i+1] = (Idx < rounds) ? d_step : dec[i];
  end

  assign result = decrypt ? dec[MAX_ROUNDS] : (enc[0] ^ FINAL_WHITEN);

endmodule

`default_nettype wire

>>> sv/rxbc_cfg.sv
// Configuration register file; the round count is derived once at key write.
`default_nettype none

module rxbc_cfg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [rxbc_pkg::IDX_W-1:0]    cfg_index,
  input  rxbc_pkg::block_t              cfg_data,
  output rxbc_pkg::cfg_t                cfg
);
  import rxbc_pkg::*;

  cfg_t regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.key     <= '0;
      regs.decrypt <= 1'b0;
      regs.mode    <= MODE_ECB;
      regs.iv      <= '0;
      regs.nonce   <= '0;
      regs.rounds  <= round_count('0);
    end else if (cfg_write) begin
      case (cfg_index)
        REG_CIPHER_KEY: begin
          regs.key    <= cfg_data;
          regs.rounds <= round_count(cfg_data);
        end
        REG_DIRECTION:     regs.decrypt <= cfg_data[0];
        REG_CHAIN_MODE:    regs.mode    <= chain_mode_t'(cfg_data[1:0]);
        REG_INIT_VECTOR:   regs.iv      <= cfg_data;
        REG_COUNTER_NONCE: regs.nonce   <= cfg_data[NONCE_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = regs;

endmodule

`default_nettype wire

>>> sv/rotate_xor_block_cipher_16bit.sv
// Top level of the 16-bit rotate-and-xor block cipher with ECB, CBC and CTR chaining.
//
//   Channel  Direction  Carries
//   din      in         block_in[15:0], first_block, tail_only
//   dout     out        block_out[15:0], tail_flag
//   cfg      in         cfg_write, cfg_index[2:0], cfg_data[15:0]
//
// One item per cycle unless dout stalls; items pass input, then result register.
// All fifteen rounds and the chaining sit between the input and result registers,
// so CBC and CTR feedback is ready for the next item in the following cycle.
// Reset (rst, synchronous) clears the valid flags, config, chain value and counter.
// A stalled dout holds the result register and, once the input register is full,
// drops din.ready.
`default_nettype none

module rotate_xor_block_cipher_16bit (
  input  logic                          clk,
  input  logic                          rst,
  rxbc_in_if.sink                       din,
  rxbc_out_if.source                    dout,
  input  logic                          cfg_write,
  input  logic [rxbc_pkg::IDX_W-1:0]    cfg_index,
  input  rxbc_pkg::block_t              cfg_data
);
  import rxbc_pkg::*;
  `include "rotate_xor_block_cipher_16bit_macros.svh"

  cfg_t cfg;

  rxbc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Input register.
  logic   a_valid;
  block_t a_block;
  logic   a_first;
  logic   a_tail;

  // Result register.
  logic   b_valid;
  block_t b_block;
  logic   b_tail;

  // Chaining state.
  block_t chain_value, chain_value_next;
  block_t block_counter, block_counter_next;

  logic b_load;
  logic a_fire;
  logic in_fire;

  assign b_load  = !b_valid || dout.ready;
  assign a_fire  = a_valid && b_load;
  assign din.ready = !a_valid || b_load;
  assign in_fire = din.valid && din.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (din.ready) begin
      a_valid <= din.valid;
    end
  end

  // The low byte of a tail item is forced to zero on capture.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      a_block <= din.tail_only ? {din.block_in[BLOCK_W-1:NONCE_W], NONCE_W'(0)}
                               : din.block_in;
      a_first <= din.first_block;
      a_tail  <= din.tail_only;
    end
  end

  // Single pass through the cipher.
  block_t chain_cur;
  block_t ctr_cur;
  block_t cipher_in;
  block_t cipher_out;
  block_t res_full;
  logic   use_decrypt;

  assign chain_cur   = a_first ? cfg.iv : chain_value;
  assign ctr_cur     = a_first ? {cfg.nonce, NONCE_W'(0)} : block_counter;
  assign use_decrypt = cfg.decrypt && (cfg.mode != MODE_CTR);

  always_comb begin
    case (cfg.mode)
      MODE_CTR: cipher_in = ctr_cur;
      MODE_CBC: cipher_in = cfg.decrypt ? a_block : (a_block ^ chain_cur);
      default:  cipher_in = a_block;
    endcase
  end

  rxbc_cipher u_cipher (
    .data    (cipher_in),
    .key     (cfg.key),
    .rounds  (cfg.rounds),
    .decrypt (use_decrypt),
    .result  (cipher_out)
  );

  always_comb begin
    res_full           = '0;
    chain_value_next   = chain_cur;
    block_counter_next = ctr_cur;
    case (cfg.mode)
      MODE_ECB: res_full = cipher_out;
      MODE_CBC: begin
        if (cfg.decrypt) begin
          res_full         = cipher_out ^ chain_cur;
          chain_value_next = a_block;
        end else begin
          res_full         = cipher_out;
          chain_value_next = cipher_out;
        end
      end
      MODE_CTR: begin
        res_full           = cipher_out ^ a_block;
        block_counter_next = ctr_cur + BLOCK_W'(1);
      end
      default: res_full = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chain_value   <= '0;
      block_counter <= '0;
      b_valid       <= 1'b0;
    end else begin
      if (a_fire) begin
        chain_value   <= chain_value_next;
        block_counter <= block_counter_next;
      end
      if (b_load) begin
        b_valid <= a_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_fire) begin
      b_block <= a_tail ? {res_full[BLOCK_W-1:NONCE_W], NONCE_W'(0)} : res_full;
      b_tail  <= a_tail;
    end
  end

  assign dout.valid     = b_valid;
  assign dout.block_out = b_block;
  assign dout.tail_flag = b_tail;

  logic   stall_hold;
  logic   ctr_step;
  block_t ctr_inc;

  assign stall_hold = a_valid && !b_load;
  assign ctr_step   = a_fire && !a_first && (cfg.mode == MODE_CTR);
  assign ctr_inc    = block_counter + BLOCK_W'(1);

  `RXBC_ASSERT_NEXT(a_held_on_stall, stall_hold, a_valid && $stable(a_block), "input item lost")
  `RXBC_ASSERT_NEXT(result_follows, a_fire, dout.valid, "item missing from result register")
  `RXBC_ASSERT_NOW(empty_accepts, !a_valid && !dout.valid, din.ready, "empty block refused item")
  `RXBC_ASSERT_NEXT(ctr_advances, ctr_step, block_counter == $past(ctr_inc), "counter stuck")

endmodule

`default_nettype wire
